// ===== rtl/hsr_pkg.sv =====
// Shared types and constants for the Heron square root block.
package hsr_pkg;

  localparam int FIELD_W = 16;
  localparam int ITER_W  = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_GUESS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 2'd2;

  localparam logic [FIELD_W-1:0] RST_INITIAL_GUESS  = 16'd256;
  localparam logic [FIELD_W-1:0] RST_TOLERANCE      = 16'd1;
  localparam logic [ITER_W-1:0]  RST_MAX_ITERATIONS = 10'd1000;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic update;
  } hsr_cmd_t;

  typedef struct packed {
    logic est_zero;
    logic within_tol;
  } hsr_sts_t;

endpackage

// ===== rtl/hsr_dpath.sv =====
// Datapath: estimate, radicand, restoring divider and Heron update.
module hsr_dpath #(
  parameter int WIDTH     = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                         clk,
  input  hsr_pkg::hsr_cmd_t            cmd,
  input  logic [hsr_pkg::FIELD_W-1:0]  value,
  input  logic [hsr_pkg::FIELD_W-1:0]  initial_guess,
  input  logic [hsr_pkg::FIELD_W-1:0]  tolerance,
  output hsr_pkg::hsr_sts_t            sts,
  output logic [hsr_pkg::FIELD_W-1:0]  root
);

  localparam int NW = WIDTH + FRAC_BITS;
  localparam int CW = (WIDTH > hsr_pkg::FIELD_W) ? WIDTH : hsr_pkg::FIELD_W;
  localparam logic [NW-1:0] EST_MAX = NW'({WIDTH{1'b1}});

  logic [WIDTH-1:0] value_r, est_r, prev_r, rem_r;
  logic [NW-1:0]    dq_r;

  logic [CW-1:0]    value_ext, guess_ext, tol_ext, diff_ext, est_ext;
  logic [WIDTH:0]   rem_sh, rem_sub;
  logic             q_bit;
  logic [NW:0]      sum;
  logic [NW-1:0]    half, est_sat;
  logic [WIDTH-1:0] diff;

  assign value_ext = CW'(value);
  assign guess_ext = CW'(initial_guess);
  assign tol_ext   = CW'(tolerance);

  assign rem_sh  = {rem_r, dq_r[NW-1]};
  assign rem_sub = rem_sh - {1'b0, est_r};
  assign q_bit   = (rem_sh >= {1'b0, est_r});

  assign sum     = (NW+1)'(est_r) + (NW+1)'(dq_r);
  assign half    = sum[NW:1];
  assign est_sat = (half > EST_MAX) ? EST_MAX : half;

  assign diff     = (est_r > prev_r) ? (est_r - prev_r) : (prev_r - est_r);
  assign diff_ext = CW'(diff);
  assign est_ext  = CW'(est_r);

  assign sts.est_zero   = (est_r == '0);
  assign sts.within_tol = (diff_ext < tol_ext);
  assign root           = est_ext[hsr_pkg::FIELD_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= value_ext[WIDTH-1:0];
      est_r   <= guess_ext[WIDTH-1:0];
    end
    if (cmd.div_init) begin
      dq_r  <= NW'(value_r) << FRAC_BITS;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dq_r  <= {dq_r[NW-2:0], q_bit};
      rem_r <= q_bit ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
    end
    if (cmd.update) begin
      prev_r <= est_r;
      est_r  <= est_sat[WIDTH-1:0];
    end
  end

endmodule

// ===== rtl/hsr_ctrl.sv =====
// Controller: sequences Heron steps, divider bits and result hand-off.
module hsr_ctrl #(
  parameter int WIDTH     = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        out_free,
  input  logic [hsr_pkg::ITER_W-1:0]  max_iterations,
  input  hsr_pkg::hsr_sts_t           sts,
  output hsr_pkg::hsr_cmd_t           cmd,
  output logic                        idle,
  output logic                        out_load,
  output logic                        conv
);

  localparam int NW  = WIDTH + FRAC_BITS;
  localparam int BCW = $clog2(NW);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_CMP    = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]                  state_r, state_nxt;
  logic [hsr_pkg::ITER_W-1:0]  it_r, it_nxt;
  logic [BCW-1:0]              bit_r, bit_nxt;
  logic                        conv_r, conv_nxt;

  always_comb begin
    state_nxt = state_r;
    it_nxt    = it_r;
    bit_nxt   = bit_r;
    conv_nxt  = conv_r;
    cmd       = '0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          it_nxt    = '0;
          conv_nxt  = 1'b0;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (it_r == max_iterations || sts.est_zero) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.div_init = 1'b1;
          bit_nxt      = '0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        bit_nxt      = bit_r + 1'b1;
        if (bit_r == BCW'(NW - 1)) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        it_nxt     = it_r + 1'b1;
        state_nxt  = ST_CMP;
      end
      ST_CMP: begin
        if (sts.within_tol) begin
          conv_nxt  = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_START;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      it_r    <= '0;
      bit_r   <= '0;
      conv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      it_r    <= it_nxt;
      bit_r   <= bit_nxt;
      conv_r  <= conv_nxt;
    end
  end

  assign idle = (state_r == ST_IDLE);
  assign conv = conv_r;

endmodule

// ===== rtl/heron_square_root.sv =====
// Top level of the Heron square root block: config registers, output register, checks.
//
// Usage: one unsigned fixed-point radicand (WIDTH bits, FRAC_BITS fractional) per
// input beat on in_value; one beat on out_root / out_converged per radicand.
// A beat moves when valid is high and stall is low. Registers are written on
// the cfg channel (index 0 initial guess, 1 tolerance, 2 iteration limit),
// cfg_ready is always high; other indexes are ignored. Write only when idle.
// Each Heron step runs a restoring divider over WIDTH+FRAC_BITS quotient
// bits, one quotient bit per cycle, between the start check and the update
// and tolerance compare states (default parameters give Q8.8). An item ends
// when the tolerance test passes, or when the iteration limit or a zero
// estimate stops it at the start check of a step; the number of steps is
// at most the iteration limit. One item is in work at a time;
// in_stall stays high from acceptance until the result is moved into the
// output register, which can hold a finished result while the next radicand
// is taken. A stalled output beat holds; the block waits to deliver only if
// the output register is full and stalled. Reset empties the output register,
// returns the controller to idle and loads guess 256, tolerance 1, limit 1000.
module heron_square_root #(
  parameter int WIDTH     = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hsr_pkg::FIELD_W-1:0]     in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hsr_pkg::FIELD_W-1:0]     out_root,
  output logic                            out_converged,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hsr_pkg::FIELD_W-1:0]     cfg_wdata
);

  logic [hsr_pkg::FIELD_W-1:0] guess_r, tol_r, root_r;
  logic [hsr_pkg::ITER_W-1:0]  max_it_r;
  logic                        out_valid_r, conv_out_r;

  hsr_pkg::hsr_cmd_t           cmd;
  hsr_pkg::hsr_sts_t           sts;
  logic                        idle, out_load, conv, out_free, in_accept;
  logic [hsr_pkg::FIELD_W-1:0] root;

  assign cfg_ready = 1'b1;
  assign in_stall  = !idle;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guess_r  <= hsr_pkg::RST_INITIAL_GUESS;
      tol_r    <= hsr_pkg::RST_TOLERANCE;
      max_it_r <= hsr_pkg::RST_MAX_ITERATIONS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hsr_pkg::CFG_INITIAL_GUESS:  guess_r  <= cfg_wdata;
        hsr_pkg::CFG_TOLERANCE:      tol_r    <= cfg_wdata;
        hsr_pkg::CFG_MAX_ITERATIONS: max_it_r <= cfg_wdata[hsr_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      root_r     <= root;
      conv_out_r <= conv;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_root      = root_r;
  assign out_converged = conv_out_r;

  hsr_ctrl #(
    .WIDTH     (WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (in_accept),
    .out_free       (out_free),
    .max_iterations (max_it_r),
    .sts            (sts),
    .cmd            (cmd),
    .idle           (idle),
    .out_load       (out_load),
    .conv           (conv)
  );

  hsr_dpath #(
    .WIDTH     (WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk           (clk),
    .cmd           (cmd),
    .value         (in_value),
    .initial_guess (guess_r),
    .tolerance     (tol_r),
    .sts           (sts),
    .root          (root)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("block not busy after taking a radicand");

  a_conv_needs_tol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && conv_out_r |-> tol_r != '0)
    else $error("converged flag with zero tolerance");

  a_zero_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && max_it_r == '0 |-> !conv)
    else $error("converged flag with zero iteration limit");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result loaded over an undelivered beat");

endmodule
